/* design/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared constants, types and helpers for the matrix factorization SGD core.
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int NUM_USERS_DEF   = 1024;
  localparam int NUM_ITEMS_DEF   = 1024;
  localparam int NUM_FACTORS_DEF = 16;

  localparam int IDX_W     = 10;
  localparam int FI_W      = 4;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SCORE_W   = 32;

  localparam int PROD_W = 32;
  localparam int DIFF_W = 34;
  localparam int ERR_W  = 44;
  localparam int G_W    = 37;

  localparam logic [1:0] OP_WR_USER = 2'd0;
  localparam logic [1:0] OP_WR_ITEM = 2'd1;
  localparam logic [1:0] OP_PREDICT = 2'd2;
  localparam logic [1:0] OP_TRAIN   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd1;

  localparam logic [CFG_W-1:0] LR_RESET    = 16'd655;
  localparam logic [CFG_W-1:0] DECAY_RESET = 16'd0;

  typedef struct packed {
    logic wr_user;
    logic wr_item;
    logic rd;
    logic mul;
    logic shift;
    logic upd_a;
    logic upd_b;
    logic upd_c;
    logic upd_d;
    logic upd_e;
  } cell_ctrl_t;

  // row index modulo a constant row count, restoring subtract
  function automatic logic [IDX_W-1:0] row_wrap(input logic [IDX_W-1:0] v, input int n);
    logic [2*IDX_W-1:0] r;
    logic [2*IDX_W-1:0] m;
    r = {{IDX_W{1'b0}}, v};
    m = '0;
    if (n < (1 << IDX_W)) begin
      for (int k = IDX_W - 1; k >= 0; k--) begin
        m = (2*IDX_W)'(n) << k;
        if (r >= m) begin
          r = r - m;
        end
      end
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [39:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/matrix_factorization_sgd_step_core.sv */
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_step_core
// Matrix factorization scorer and SGD trainer built as a chain of factor cells.
// ----------------------------------------------------------------------------
// One item is handled at a time. A write stores one element in the selected
// cell. A predict reads the row, multiplies in every cell, then the product
// chain shifts one lane product per cycle into the head accumulator before
// the sum is saturated. A train step then runs the error stages and the
// multiply/add stages of the update pipeline. Each cell keeps one factor
// column of both tables in its own single-port memory, so a row is read, or
// updated by a train step, across all cells in the same cycle. Tables are not
// cleared at reset; software loads them. A finished score waits in the output
// register while the next item is taken.
// ----------------------------------------------------------------------------
module matrix_factorization_sgd_step_core import mfs_pkg::*; #(
  parameter int NUM_USERS   = NUM_USERS_DEF,
  parameter int NUM_ITEMS   = NUM_ITEMS_DEF,
  parameter int NUM_FACTORS = NUM_FACTORS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [IDX_W-1:0]          user_index,
  input  logic [IDX_W-1:0]          item_index,
  input  logic [FI_W-1:0]           factor_index,
  input  logic signed [VAL_W-1:0]   write_value,
  input  logic [VAL_W-1:0]          confidence,
  input  logic signed [VAL_W-1:0]   target,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SCORE_W-1:0] score,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int UR_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int IR_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;

  cell_ctrl_t ctrl;
  logic [UR_W-1:0] user_row;
  logic [IR_W-1:0] item_row;
  logic [FI_W-1:0] factor_sel;
  logic signed [VAL_W-1:0] wv;
  logic signed [ERR_W-1:0] err;
  logic [CFG_W-1:0] lr, decay;
  logic signed [PROD_W-1:0] chain [NUM_FACTORS+1];

  assign chain[NUM_FACTORS] = '0;

  mfs_ctrl #(
    .NUM_USERS   (NUM_USERS),
    .NUM_ITEMS   (NUM_ITEMS),
    .NUM_FACTORS (NUM_FACTORS),
    .UR_W        (UR_W),
    .IR_W        (IR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .user_index   (user_index),
    .item_index   (item_index),
    .factor_index (factor_index),
    .write_value  (write_value),
    .confidence   (confidence),
    .target       (target),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .score        (score),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctrl         (ctrl),
    .user_row     (user_row),
    .item_row     (item_row),
    .factor_sel   (factor_sel),
    .wv           (wv),
    .err          (err),
    .lr           (lr),
    .decay        (decay),
    .head_prod    (chain[0])
  );

  for (genvar f = 0; f < NUM_FACTORS; f++) begin : g_cell
    mfs_cell #(
      .NUM_USERS (NUM_USERS),
      .NUM_ITEMS (NUM_ITEMS),
      .CELL_IDX  (f),
      .UR_W      (UR_W),
      .IR_W      (IR_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .user_row    (user_row),
      .item_row    (item_row),
      .factor_sel  (factor_sel),
      .write_value (wv),
      .err         (err),
      .lr          (lr),
      .decay       (decay),
      .prod_in     (chain[f+1]),
      .prod_out    (chain[f])
    );
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while sequencer busy");

  a_cells_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (ctrl == '0))
    else $error("cell command issued while idle");

endmodule

/* design/mfs_cell.sv */
// ----------------------------------------------------------------------------
// mfs_cell
// One factor lane: holds one column of both tables, forms the lane product
// that shifts toward the head, and updates its user and item elements.
// ----------------------------------------------------------------------------
module mfs_cell import mfs_pkg::*; #(
  parameter int NUM_USERS = NUM_USERS_DEF,
  parameter int NUM_ITEMS = NUM_ITEMS_DEF,
  parameter int CELL_IDX  = 0,
  parameter int UR_W      = 10,
  parameter int IR_W      = 10
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [UR_W-1:0]          user_row,
  input  logic [IR_W-1:0]          item_row,
  input  logic [FI_W-1:0]          factor_sel,
  input  logic signed [VAL_W-1:0]  write_value,
  input  logic signed [ERR_W-1:0]  err,
  input  logic [CFG_W-1:0]         lr,
  input  logic [CFG_W-1:0]         decay,
  input  logic signed [PROD_W-1:0] prod_in,
  output logic signed [PROD_W-1:0] prod_out
);

  logic signed [VAL_W-1:0] umem [NUM_USERS];
  logic signed [VAL_W-1:0] vmem [NUM_ITEMS];
  logic signed [VAL_W-1:0] u_q, v_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [37:0] pu, pv;
  logic signed [38:0] qu, qv;
  logic signed [32:0] ru, rv;
  logic signed [G_W-1:0] gu, gv;
  logic signed [35:0] mlu, mhu, mlv, mhv;
  logic signed [VAL_W-1:0] nu, nv;
  logic signed [21:0] el;
  logic signed [22:0] eh;
  logic signed [16:0] lr_s, decay_s;
  logic signed [60:0] tu, tv;
  logic signed [54:0] su, sv;
  logic sel, uwe, vwe;
  logic signed [VAL_W-1:0] uwd, vwd;

  assign sel     = (int'(factor_sel) == CELL_IDX);
  assign el      = $signed({1'b0, err[20:0]});
  assign eh      = $signed(err[ERR_W-1:21]);
  assign lr_s    = $signed({1'b0, lr});
  assign decay_s = $signed({1'b0, decay});

  assign tu = (61'(qu) <<< 21) + 61'(pu) - (61'(ru) <<< 8);
  assign tv = (61'(qv) <<< 21) + 61'(pv) - (61'(rv) <<< 8);
  assign su = (55'(mhu) <<< 18) + 55'(mlu);
  assign sv = (55'(mhv) <<< 18) + 55'(mlv);

  assign uwe = ctrl.upd_e | (ctrl.wr_user & sel);
  assign vwe = ctrl.upd_e | (ctrl.wr_item & sel);
  assign uwd = ctrl.upd_e ? nu : write_value;
  assign vwd = ctrl.upd_e ? nv : write_value;

  always_ff @(posedge clk) begin
    if (uwe) begin
      umem[user_row] <= uwd;
    end
    if (ctrl.rd) begin
      u_q <= umem[user_row];
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[item_row] <= vwd;
    end
    if (ctrl.rd) begin
      v_q <= vmem[item_row];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      prod <= u_q * v_q;
    end else if (ctrl.shift) begin
      prod <= prod_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd_a) begin
      pu <= el * v_q;
      pv <= el * u_q;
      qu <= eh * v_q;
      qv <= eh * u_q;
      ru <= decay_s * u_q;
      rv <= decay_s * v_q;
    end
    if (ctrl.upd_b) begin
      gu <= tu[60:24];
      gv <= tv[60:24];
    end
    if (ctrl.upd_c) begin
      mlu <= lr_s * $signed({1'b0, gu[17:0]});
      mhu <= lr_s * $signed(gu[G_W-1:18]);
      mlv <= lr_s * $signed({1'b0, gv[17:0]});
      mhv <= lr_s * $signed(gv[G_W-1:18]);
    end
    if (ctrl.upd_d) begin
      nu <= sat16(40'(u_q) + 40'($signed(su[54:16])));
      nv <= sat16(40'(v_q) + 40'($signed(sv[54:16])));
    end
  end

  assign prod_out = prod;

endmodule

/* design/mfs_ctrl.sv */
// ----------------------------------------------------------------------------
// mfs_ctrl
// Sequencer: handshakes, config registers, dot product accumulation at the
// head of the cell chain, error term and result register.
// ----------------------------------------------------------------------------
module mfs_ctrl import mfs_pkg::*; #(
  parameter int NUM_USERS   = NUM_USERS_DEF,
  parameter int NUM_ITEMS   = NUM_ITEMS_DEF,
  parameter int NUM_FACTORS = NUM_FACTORS_DEF,
  parameter int UR_W        = 10,
  parameter int IR_W        = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [IDX_W-1:0]          user_index,
  input  logic [IDX_W-1:0]          item_index,
  input  logic [FI_W-1:0]           factor_index,
  input  logic signed [VAL_W-1:0]   write_value,
  input  logic [VAL_W-1:0]          confidence,
  input  logic signed [VAL_W-1:0]   target,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SCORE_W-1:0] score,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output cell_ctrl_t                ctrl,
  output logic [UR_W-1:0]           user_row,
  output logic [IR_W-1:0]           item_row,
  output logic [FI_W-1:0]           factor_sel,
  output logic signed [VAL_W-1:0]   wv,
  output logic signed [ERR_W-1:0]   err,
  output logic [CFG_W-1:0]          lr,
  output logic [CFG_W-1:0]          decay,
  input  logic signed [PROD_W-1:0]  head_prod
);

  localparam int CNT_W = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
  localparam int ACC_W = PROD_W + CNT_W + 1;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32'sh7fffffff);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'($signed(32'h80000000));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WR   = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_SAT  = 4'd5;
  localparam logic [3:0] S_DIFF = 4'd6;
  localparam logic [3:0] S_EMUL = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;
  localparam logic [3:0] S_UA   = 4'd9;
  localparam logic [3:0] S_UB   = 4'd10;
  localparam logic [3:0] S_UC   = 4'd11;
  localparam logic [3:0] S_UD   = 4'd12;
  localparam logic [3:0] S_UE   = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state;
  logic [1:0] op_q;
  logic [VAL_W-1:0] conf_q;
  logic signed [VAL_W-1:0] tgt_q;
  logic [CNT_W-1:0] cnt;
  logic signed [ACC_W-1:0] acc;
  logic signed [SCORE_W-1:0] pred;
  logic signed [DIFF_W-1:0] diff;
  logic signed [34:0] plo;
  logic signed [33:0] phi;
  logic signed [51:0] psum;
  logic signed [16:0] conf_s;

  assign in_ready = (state == S_IDLE);
  assign conf_s   = $signed({1'b0, conf_q});
  assign psum     = (52'(phi) <<< 17) + 52'(plo);

  always_comb begin
    ctrl         = '0;
    ctrl.wr_user = (state == S_WR) && (op_q == OP_WR_USER);
    ctrl.wr_item = (state == S_WR) && (op_q == OP_WR_ITEM);
    ctrl.rd      = (state == S_RD);
    ctrl.mul     = (state == S_MUL);
    ctrl.shift   = (state == S_SUM);
    ctrl.upd_a   = (state == S_UA);
    ctrl.upd_b   = (state == S_UB);
    ctrl.upd_c   = (state == S_UC);
    ctrl.upd_d   = (state == S_UD);
    ctrl.upd_e   = (state == S_UE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lr    <= LR_RESET;
      decay <= DECAY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LR) begin
        lr <= cfg_data;
      end else if (cfg_index == CFG_DECAY) begin
        decay <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            user_row   <= UR_W'(row_wrap(user_index, NUM_USERS));
            item_row   <= IR_W'(row_wrap(item_index, NUM_ITEMS));
            factor_sel <= factor_index;
            wv         <= write_value;
            conf_q     <= confidence;
            tgt_q      <= target;
            state      <= (op == OP_PREDICT || op == OP_TRAIN) ? S_RD : S_WR;
          end
        end
        S_WR: begin
          pred  <= '0;
          state <= S_DONE;
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          acc   <= '0;
          cnt   <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          acc <= acc + ACC_W'(head_prod);
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUM_FACTORS - 1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (acc > SMAX) begin
            pred <= SMAX[SCORE_W-1:0];
          end else if (acc < SMIN) begin
            pred <= SMIN[SCORE_W-1:0];
          end else begin
            pred <= acc[SCORE_W-1:0];
          end
          state <= (op_q == OP_TRAIN) ? S_DIFF : S_DONE;
        end
        S_DIFF: begin
          diff  <= (DIFF_W'(tgt_q) <<< 12) - DIFF_W'(pred);
          state <= S_EMUL;
        end
        S_EMUL: begin
          plo   <= conf_s * $signed({1'b0, diff[16:0]});
          phi   <= conf_s * $signed(diff[DIFF_W-1:17]);
          state <= S_ERR;
        end
        S_ERR: begin
          err   <= psum[51:8];
          state <= S_UA;
        end
        S_UA: state <= S_UB;
        S_UB: state <= S_UC;
        S_UC: state <= S_UD;
        S_UD: state <= S_UE;
        S_UE: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            score     <= pred;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
